/* hw/rtl/tgq_pkg.sv */
// shared types and constants of the team grouped queue
package tgq_pkg;

  localparam int NUM_TEAMS = 16;
  localparam int CAPACITY  = 256;
  localparam int ELEM_BITS = 16;
  localparam int TEAM_BITS = $clog2(NUM_TEAMS);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int TCNT_BITS = $clog2(NUM_TEAMS + 1);

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef logic [TEAM_BITS-1:0] team_t;
  typedef logic [ELEM_BITS-1:0] elem_t;

  // one queue slot
  typedef struct packed {
    logic  valid;
    team_t team;
    elem_t value;
  } cell_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 enq;
    logic                 deq;
    team_t                team;
    elem_t                value;
    logic [NUM_TEAMS-1:0] behind;
  } cell_ctrl_t;

  // commands to the team bookkeeping
  typedef struct packed {
    logic  enq;
    logic  deq_last;
    team_t enq_team;
    team_t head_team;
  } team_cmd_t;

  // boundary seen by the first cell: occupied, never moves
  localparam cell_t EDGE_CELL = '{valid: 1'b1, team: '0, value: '0};

endpackage

/* hw/rtl/tgq_req_if.sv */
// request channel of the team grouped queue
interface tgq_req_if;
  import tgq_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  team_t team_id;
  elem_t element_in;

  modport source (output valid, output func, output team_id, output element_in, input ready);
  modport sink   (input valid, input func, input team_id, input element_in, output ready);
endinterface

/* hw/rtl/tgq_rsp_if.sv */
// response channel of the team grouped queue
interface tgq_rsp_if;
  import tgq_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  elem_t               element_out;
  logic [CNT_BITS-1:0] occupancy;

  modport source (output valid, output status, output element_out, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input element_out, input occupancy,
                  output ready);
endinterface

/* hw/rtl/tgq_cell.sv */
// one slot of the queue chain: moves right on insert, left on removal
module tgq_cell (
  input  logic               clk,
  input  logic               rst,
  input  tgq_pkg::cell_ctrl_t ctrl,
  input  tgq_pkg::cell_t     left,
  input  logic               left_shift,
  input  tgq_pkg::cell_t     right,
  output tgq_pkg::cell_t     cur,
  output logic               shift
);
  import tgq_pkg::*;

  cell_t cur_next;
  logic  insert;

  // occupied slots whose team sits behind the target team make room
  assign shift  = ctrl.enq & cur.valid & ctrl.behind[cur.team];
  // new element lands at the boundary between staying and moving slots
  assign insert = ctrl.enq & (shift | ~cur.valid) & left.valid & ~left_shift;

  always_comb begin
    cur_next = cur;
    if (ctrl.deq) begin
      cur_next = right;
    end else if (insert) begin
      cur_next.valid = 1'b1;
      cur_next.team  = ctrl.team;
      cur_next.value = ctrl.value;
    end else if (left_shift) begin
      // neighbor steps back into this slot, including the first free one
      cur_next = left;
    end
  end

  always_ff @(posedge clk) begin
    cur.team  <= cur_next.team;
    cur.value <= cur_next.value;
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
  end
endmodule

/* hw/rtl/tgq_team_ctrl.sv */
// per-team presence and order of the team groups in the queue
module tgq_team_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  tgq_pkg::team_cmd_t            cmd,
  output logic [tgq_pkg::NUM_TEAMS-1:0] behind
);
  import tgq_pkg::*;

  logic [NUM_TEAMS-1:0] present;
  team_t                slot [NUM_TEAMS];
  team_t                start;
  logic [TCNT_BITS-1:0] team_count;
  team_t                rank [NUM_TEAMS];
  team_t                rank_t;

  assign rank_t = team_t'(slot[cmd.enq_team] - start);

  always_comb begin
    for (int k = 0; k < NUM_TEAMS; k++) begin
      rank[k]   = team_t'(slot[k] - start);
      behind[k] = present[k] & present[cmd.enq_team] & (rank[k] > rank_t);
    end
  end

  // slot positions need no reset, presence guards them
  always_ff @(posedge clk) begin
    if (cmd.enq && !present[cmd.enq_team]) begin
      slot[cmd.enq_team] <= team_t'(start + team_count[TEAM_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      start      <= '0;
      team_count <= '0;
    end else if (cmd.enq && !present[cmd.enq_team]) begin
      present[cmd.enq_team] <= 1'b1;
      team_count            <= team_count + TCNT_BITS'(1);
    end else if (cmd.deq_last) begin
      present[cmd.head_team] <= 1'b0;
      start                  <= start + team_t'(1);
      team_count             <= team_count - TCNT_BITS'(1);
    end
  end
endmodule

/* hw/rtl/team_grouped_queue.sv */
// team grouped queue: requests go in, one response per request comes out of the output register
// throughput: one request per cycle; ready drops only while a response waits on a stalled sink
// each request is settled in the cycle it is taken: every slot of the cell chain moves at once
// reset: synchronous, clears slot valid bits, team presence, team order and occupancy
// no clearing pass after reset; the block takes requests in the first cycle after reset
module team_grouped_queue (
  input logic clk,
  input logic rst,
  tgq_req_if.sink   req,
  tgq_rsp_if.source rsp
);
  import tgq_pkg::*;

  // chain of slots, slot 0 is the head of the queue
  cell_t cells  [CAPACITY];
  logic  shifts [CAPACITY];

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;

  logic       fire;
  logic       is_enq;
  logic       enq_go;
  logic       deq_go;
  logic       head_last;
  logic [1:0] status_next;
  elem_t      elem_next;

  cell_ctrl_t           ctrl;
  team_cmd_t            cmd;
  logic [NUM_TEAMS-1:0] behind;

  // the output register frees itself when the sink takes it
  assign req.ready = ~rsp.valid | rsp.ready;
  assign fire      = req.valid & req.ready;
  assign is_enq    = (req.func == FUNC_ENQ);

  // full queue refuses enqueue, empty queue refuses dequeue
  assign enq_go = fire & is_enq & (count != CNT_BITS'(CAPACITY));
  assign deq_go = fire & ~is_enq & (count != '0);

  // head team loses its last member when slot 1 holds another team or nothing
  assign head_last = ~(cells[1].valid & (cells[1].team == cells[0].team));

  assign cmd.enq       = enq_go;
  assign cmd.deq_last  = deq_go & head_last;
  assign cmd.enq_team  = req.team_id;
  assign cmd.head_team = cells[0].team;

  tgq_team_ctrl u_team_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .behind (behind)
  );

  // broadcast to the chain: which teams must step back to open a gap
  assign ctrl.enq    = enq_go;
  assign ctrl.deq    = deq_go;
  assign ctrl.team   = req.team_id;
  assign ctrl.value  = req.element_in;
  assign ctrl.behind = behind;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t left_c;
    cell_t right_c;
    logic  left_sh;

    // the slot in front of the head counts as occupied and fixed
    if (i == 0) begin : g_head
      assign left_c  = EDGE_CELL;
      assign left_sh = 1'b0;
    end else begin : g_mid
      assign left_c  = cells[i-1];
      assign left_sh = shifts[i-1];
    end

    // past the last slot nothing comes in on a removal
    if (i == CAPACITY - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_body
      assign right_c = cells[i+1];
    end

    tgq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left       (left_c),
      .left_shift (left_sh),
      .right      (right_c),
      .cur        (cells[i]),
      .shift      (shifts[i])
    );
  end

  // occupancy and response fields
  always_comb begin
    count_next  = count;
    status_next = STATUS_OK;
    elem_next   = '0;
    if (enq_go) begin
      count_next = count + CNT_BITS'(1);
    end else if (deq_go) begin
      count_next = count - CNT_BITS'(1);
      elem_next  = cells[0].value;
    end else if (is_enq) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // response register, payload has no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status      <= status_next;
      rsp.element_out <= elem_next;
      rsp.occupancy   <= count_next;
    end
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // occupancy never exceeds the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY))
    else $error("occupancy above capacity");

  // head slot is occupied exactly when the queue holds something
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    cells[0].valid == (count != '0))
    else $error("head slot disagrees with occupancy");

  // a successful dequeue reports ok with the new occupancy
  a_deq_resp: assert property (@(posedge clk) disable iff (rst)
    deq_go |=> rsp.valid && rsp.status == STATUS_OK && rsp.occupancy == count)
    else $error("dequeue response wrong");

  // a refused request leaves the occupancy unchanged
  a_refuse_hold: assert property (@(posedge clk) disable iff (rst)
    fire && !enq_go && !deq_go |=> rsp.occupancy == $past(count))
    else $error("refused request changed occupancy");
`endif
endmodule
